// ----- src/pcpt_pkg.sv -----
// Package: payload types, field widths and codes for the projector color phase tagger.
`default_nettype none

package pcpt_pkg;

    localparam int TIME_BITS  = 48;
    localparam int COORD_BITS = 11;
    localparam int CFG_BITS   = 16;

    // configuration register indexes
    localparam logic CFG_EXPOSURE = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    // operation codes
    localparam logic OP_TRIGGER = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    // color tags
    localparam logic [1:0] TAG_NONE  = 2'd0;
    localparam logic [1:0] TAG_RED   = 2'd1;
    localparam logic [1:0] TAG_GREEN = 2'd2;
    localparam logic [1:0] TAG_BLUE  = 2'd3;

    localparam logic [1:0] PHASE_UNSYNC = 2'd0;
    localparam logic [1:0] PHASE_ONE    = 2'd1;
    localparam logic [1:0] PHASE_TWO    = 2'd2;
    localparam logic [1:0] PHASE_THREE  = 2'd3;

    // phase start slots
    localparam int SLOT_RED   = 0;
    localparam int SLOT_GREEN = 1;
    localparam int SLOT_BLUE  = 2;
    localparam int NUM_SLOTS  = 3;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [CFG_BITS-1:0]   t_cfg;

    typedef struct packed {
        logic   op;
        t_time  stamp_us;
        logic   pol;
        t_coord col;
        t_coord row;
    } t_in_item;

    typedef struct packed {
        logic       is_pixel;
        t_coord     out_col;
        t_coord     out_row;
        logic       out_pol;
        t_time      out_stamp;
        logic [1:0] light_tag;
        logic [1:0] cur_phase;
        logic       freq_ok;
        logic       flush;
        logic       missed_blue;
        logic       bad_period;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/projector_color_phase_tagger.sv -----
// Top level: projector color phase tagger, trigger pulse classifier and pixel color tagging.
// Usage:
//   Input channel (i_valid / o_stall / i_data) carries trigger edges and pixel
//   change events in time order. Output channel (o_valid / i_stall / o_data)
//   returns exactly one result transaction per input transaction.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 exposure_us, 1 color_window_us); write only while the block is idle.
// Output: an accepted transaction is captured in the result register at the
//   edge that accepts it; the result register is the only stage.
// Throughput: one transaction per cycle while o_stall is low. The state update
//   and classification of an item is one pass through the pulse width
//   subtractor and the three window subtract/compares, all feeding the result register.
// Stall: o_stall rises only while the result register is full and the
//   receiver holds i_stall; a held result does not change. Once the receiver
//   takes it, a new transaction is accepted in the same cycle.
// Reset (i_rst_n low, synchronous): phase unsynchronized, no phase start
//   recorded, sticky color none, exposure 235 us, window 350 us, output empty.
`default_nettype none

module projector_color_phase_tagger (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire pcpt_pkg::t_cfg     i_cfg_data,
    // input transactions
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire pcpt_pkg::t_in_item i_data,
    // result transactions
    output logic                    o_valid,
    input  wire logic               i_stall,
    output pcpt_pkg::t_out_item     o_data
);
    import pcpt_pkg::*;

    // configuration
    t_cfg r_exposure;
    t_cfg r_window;

    // tracking state
    t_time                r_last_rise;
    logic [1:0]           r_phase;
    logic                 r_sync_ok;
    t_time                r_start [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_start_vld;
    logic [1:0]           r_sticky;

    // result register
    logic      r_out_vld;
    t_out_item r_out;

    logic       accept;
    logic [1:0] n_phase;
    logic       n_sync_ok;
    logic [1:0] n_sticky;
    logic       mark_red, mark_green, mark_blue;
    t_out_item  n_out;

    // pulse width classification
    logic [TIME_BITS:0]   width_full;
    t_time                width;
    logic                 rise_ok;
    logic [CFG_BITS:0]    exp_hi2;
    logic [CFG_BITS:0]    exp_hi6;
    logic [CFG_BITS-1:0]  exp_lo2;
    logic                 long_pulse;
    logic                 nom_pulse;

    // window checks
    logic [NUM_SLOTS-1:0] hit;

    // the output register drains or is empty: room for one more transaction
    assign o_stall = r_out_vld && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // width = falling stamp - last rise; a negative width is a bad period
    assign width_full = {1'b0, i_data.stamp_us} - {1'b0, r_last_rise};
    assign width      = width_full[TIME_BITS-1:0];
    assign rise_ok    = !width_full[TIME_BITS];
    assign exp_hi2    = {1'b0, r_exposure} + (CFG_BITS+1)'(2);
    assign exp_hi6    = {1'b0, r_exposure} + (CFG_BITS+1)'(6);
    assign exp_lo2    = r_exposure - CFG_BITS'(2);

    assign long_pulse = rise_ok
                     && (width > t_time'(exp_hi2))
                     && (width < t_time'(exp_hi6));
    // below an exposure of 2 the lower bound of the nominal band falls away
    assign nom_pulse  = rise_ok
                     && ((r_exposure < CFG_BITS'(2)) || (width > t_time'(exp_lo2)))
                     && (width < t_time'(exp_hi2));

    // a pixel at or before a recorded start counts as inside that window
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            hit[s] = r_start_vld[s]
                  && ((i_data.stamp_us <= r_start[s])
                   || ((i_data.stamp_us - r_start[s]) <= t_time'(r_window)));
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_sync_ok  = r_sync_ok;
        n_sticky   = r_sticky;
        mark_red   = 1'b0;
        mark_green = 1'b0;
        mark_blue  = 1'b0;

        n_out             = '0;
        n_out.is_pixel    = i_data.op;
        n_out.out_stamp   = i_data.stamp_us;

        if (i_data.op == OP_TRIGGER) begin
            if (!i_data.pol) begin
                priority if (long_pulse) begin
                    n_phase   = PHASE_ONE;
                    mark_blue = 1'b1;
                end else if (nom_pulse) begin
                    if (r_phase != PHASE_UNSYNC) begin
                        n_sync_ok = 1'b1;
                    end
                    unique case (r_phase)
                        PHASE_ONE: begin
                            n_phase  = PHASE_TWO;
                            mark_red = 1'b1;
                        end
                        PHASE_TWO: begin
                            n_phase    = PHASE_THREE;
                            mark_green = 1'b1;
                        end
                        PHASE_THREE: begin
                            n_phase           = PHASE_ONE;
                            n_sync_ok         = 1'b0;
                            n_out.missed_blue = 1'b1;
                        end
                        default: begin
                            // nominal pulse while unsynchronized: no change
                        end
                    endcase
                end else begin
                    n_phase          = PHASE_UNSYNC;
                    n_sync_ok        = 1'b0;
                    n_out.bad_period = 1'b1;
                end
                n_out.flush = mark_red || mark_green || mark_blue;
            end
        end else begin
            // blue over green over red; keep the last color if none matches
            priority if (hit[SLOT_BLUE]) begin
                n_sticky = TAG_BLUE;
            end else if (hit[SLOT_GREEN]) begin
                n_sticky = TAG_GREEN;
            end else if (hit[SLOT_RED]) begin
                n_sticky = TAG_RED;
            end
            n_out.out_col   = i_data.col;
            n_out.out_row   = i_data.row;
            n_out.out_pol   = i_data.pol;
            n_out.light_tag = n_sticky;
        end

        n_out.cur_phase = n_phase;
        n_out.freq_ok   = n_sync_ok;
    end

    // control and configuration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure  <= CFG_BITS'(235);
            r_window    <= CFG_BITS'(350);
            r_last_rise <= '0;
            r_phase     <= PHASE_UNSYNC;
            r_sync_ok   <= 1'b0;
            r_start_vld <= '0;
            r_sticky    <= TAG_NONE;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXPOSURE: r_exposure <= i_cfg_data;
                    CFG_WINDOW:   r_window   <= i_cfg_data;
                    default:      r_window   <= r_window;
                endcase
            end
            if (accept) begin
                if (i_data.op == OP_TRIGGER && i_data.pol) begin
                    r_last_rise <= i_data.stamp_us;
                end
                r_phase   <= n_phase;
                r_sync_ok <= n_sync_ok;
                r_sticky  <= n_sticky;
                if (mark_red)   r_start_vld[SLOT_RED]   <= 1'b1;
                if (mark_green) r_start_vld[SLOT_GREEN] <= 1'b1;
                if (mark_blue)  r_start_vld[SLOT_BLUE]  <= 1'b1;
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload: phase start times and the result item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (mark_red)   r_start[SLOT_RED]   <= i_data.stamp_us;
            if (mark_green) r_start[SLOT_GREEN] <= i_data.stamp_us;
            if (mark_blue)  r_start[SLOT_BLUE]  <= i_data.stamp_us;
            r_out <= n_out;
        end
    end

    // unsynchronized phase never reports a good trigger frequency
    a_unsync_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PHASE_UNSYNC) |-> !r_sync_ok)
        else $error("freq_ok set while phase is unsynchronized");

    // a missed blue always falls back to phase one with frequency judged bad
    a_missed_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.missed_blue) |->
            (r_out.cur_phase == PHASE_ONE) && !r_out.freq_ok)
        else $error("missed_blue result with wrong phase or freq_ok");

    // a bad period result drops to the unsynchronized phase
    a_bad_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.bad_period) |->
            (r_out.cur_phase == PHASE_UNSYNC) && !r_out.flush)
        else $error("bad_period result with wrong phase or flush");

    // a held result must survive a stall
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result lost or changed");

    // flush only ever comes from a trigger that recorded a phase start
    a_flush_trigger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.flush) |-> (!r_out.is_pixel && (r_start_vld != '0)))
        else $error("flush on a pixel result or without a recorded start");

endmodule

`default_nettype wire
